>>> design/segment_triangle_collision_assert.svh
// Assertion macros for the segment/triangle collision block.
// Used by segment_triangle_collision.sv; no other dependencies.
`ifndef SEGMENT_TRIANGLE_COLLISION_ASSERT_SVH
`define SEGMENT_TRIANGLE_COLLISION_ASSERT_SVH
`ifndef SYNTHESIS
`define STC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stc: implication failed");
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stc: next-cycle check failed");
`else
`define STC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/stc_pkg.sv
// Package for the segment/triangle collision block: defaults, codes, state type.
// No dependencies.
package stc_pkg;

  localparam int MAX_TRIANGLES_DEF = 64;
  localparam int COORD_BITS_DEF    = 24;
  localparam int FIELD_W           = 24;
  localparam int NUM_CORNERS       = 3;
  localparam int THRESH_RESET      = 1;

  localparam logic REG_COUNT  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef enum logic [1:0] {
    ST_PARALLEL,
    ST_OUTSIDE_SEG,
    ST_OUTSIDE_TRI,
    ST_HIT
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_PREP,
    S_CROSS_N,
    S_SHIFT,
    S_SQ,
    S_SQRT,
    S_UDIV_INIT,
    S_UDIV,
    S_DOT,
    S_CHECK,
    S_TDIV,
    S_PT,
    S_EPREP,
    S_CROSS_E,
    S_EDOT,
    S_EMIT
  } state_t;

endpackage

>>> design/segment_triangle_collision.sv
// Segment/triangle collision checker: vertex store, shared multiplier, sequencer.
// Depends on stc_pkg and segment_triangle_collision_assert.svh.
//
// Usage:
// Input channel (item_valid/item_stall) carries either a load item (mode 0),
// which writes one corner of one triangle slot, or a check item (mode 1),
// which carries segment start a and end b. A check walks slots 0 to
// triangle_count-1 (capped at MAX_TRIANGLES) and yields one result item per
// slot on the output channel (result_valid/result_stall), last set on the
// final one. A check with a zero count yields nothing.
// Per triangle the work runs on one multiplier and bit-serial units: a 32-step
// square root, three 31-step divisions for the unit normal and the 30-step
// division for t; parallel and outside cases end earlier than a hit.
// One item is in work at a time; item_stall is high until the check is done.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer holds before loading the next one.
// Reset clears the control state and the registers (count 0, threshold 1);
// the vertex store is not cleared and must be loaded before it is checked.
// APB registers: 0x0 triangle_count, 0x4 parallel_threshold.
`include "segment_triangle_collision_assert.svh"

module segment_triangle_collision
  import stc_pkg::*;
#(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      mode,
  input  logic [5:0]                tri_index,
  input  logic [1:0]                corner,
  input  logic signed [FIELD_W-1:0] ax,
  input  logic signed [FIELD_W-1:0] ay,
  input  logic signed [FIELD_W-1:0] az,
  input  logic signed [FIELD_W-1:0] bx,
  input  logic signed [FIELD_W-1:0] by,
  input  logic signed [FIELD_W-1:0] bz,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [5:0]                hit_index,
  output logic [1:0]                status,
  output logic signed [FIELD_W-1:0] px,
  output logic signed [FIELD_W-1:0] py,
  output logic signed [FIELD_W-1:0] pz,
  output logic                      last
);

  localparam int CW    = COORD_BITS;
  localparam int EW    = CW + 1;
  localparam int NW    = 2 * EW + 1;
  localparam int LOW   = NW / 2;
  localparam int HIW   = NW - LOW;
  localparam int UW    = 32;
  localparam int MUL_W = (EW + 1 > 32) ? EW + 1 : 32;
  localparam int PW    = 2 * MUL_W;
  localparam int ACW   = NW + 33;
  localparam int DNW   = UW + EW + 2;
  localparam int RW    = DNW + 1;
  localparam int TIW   = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int DEPTH = NUM_CORNERS * MAX_TRIANGLES;
  localparam int AW    = $clog2(DEPTH);

  state_t state, state_next;
  status_t sts, sts_val;

  logic [6:0]  triangle_count;
  logic [15:0] parallel_threshold;

  logic [3*CW-1:0] mem [DEPTH];
  logic [3*CW-1:0] rd_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;

  logic item_accept, out_free, cfg_write;
  logic [6:0] cnt, cnt_in;
  logic [TIW-1:0] tri_cnt;
  logic [2:0] stp, kmax;
  logic [1:0] grp, gmax, ug, eidx;
  logic [4:0] itr;
  logic grp_last, all_in, last_now, is_prod;

  logic signed [CW-1:0] cin_a [3];
  logic signed [CW-1:0] cin_b [3];
  logic signed [CW-1:0] ca [3];
  logic signed [EW-1:0] cd [3];
  logic signed [CW-1:0] v [3][3];
  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] vb [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] w0 [3];
  logic signed [EW-1:0] ee [3];
  logic signed [EW-1:0] ew [3];
  logic signed [EW-1:0] psrc [3];
  logic signed [EW-1:0] qsrc [3];
  logic signed [EW-1:0] xa0, xb0, xa1, xb1;
  logic signed [NW-1:0] nv [3];
  logic signed [NW-1:0] cc [3];
  logic signed [30:0]   mv [3];
  logic signed [HIW-1:0] chi [3];
  logic [LOW-1:0]        clo [3];
  logic signed [UW-1:0] u [3];
  logic signed [CW-1:0] pp [3];

  logic [63:0] sq_x, sq_res, sq_one, sq_t;
  logic [31:0] len;
  logic [31:0] drem;
  logic [30:0] dlow, dq, dq_nx, mabs;
  logic [32:0] dtt;
  logic        usign;
  logic [61:0] dnum;

  logic signed [DNW-1:0] dn, num, thr_ext;
  logic [DNW-1:0] rem;
  logic [RW-1:0]  rem2, dn_u;
  logic [30:0]    tq;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic mul_en, mul_neg, mul_shl;
  logic signed [PW-1:0]  prod;
  logic p_en, p_neg, p_shl;
  logic signed [ACW-1:0] acc, acc_sum, term;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;
  assign prdata      = (paddr[2] == REG_THRESH) ? {16'd0, parallel_threshold}
                                                : {25'd0, triangle_count};
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;
  assign cnt_in      = (triangle_count > 7'(MAX_TRIANGLES)) ? 7'(MAX_TRIANGLES)
                                                            : triangle_count;
  assign last_now    = (7'(tri_cnt) + 7'd1) == cnt;
  assign len         = sq_res[31:0];
  assign thr_ext     = DNW'({parallel_threshold, 30'd0});
  assign dn_u        = RW'($unsigned(dn));
  assign rem2        = {rem, 1'b0};
  assign sq_t        = sq_res + sq_one;
  assign dtt         = {drem, dlow[30]};
  assign dq_nx       = {dq[29:0], (dtt >= 33'(len))};
  assign wr_en       = item_accept && (mode == MODE_LOAD) && (corner != 2'(NUM_CORNERS))
                       && (7'(tri_index) < 7'(MAX_TRIANGLES));
  assign wr_addr     = AW'(8'(tri_index) * 8'(NUM_CORNERS) + 8'(corner));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mv[k]  = signed'(nv[k][30:0]);
      chi[k] = HIW'(cc[k] >>> LOW);
      clo[k] = cc[k][LOW-1:0];
    end
    cin_a[0] = CW'(ax);
    cin_a[1] = CW'(ay);
    cin_a[2] = CW'(az);
    cin_b[0] = CW'(bx);
    cin_b[1] = CW'(by);
    cin_b[2] = CW'(bz);
    all_in = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!(&nv[k][NW-1:30] || ~|nv[k][NW-1:30])) all_in = 1'b0;
    end
  end

  // Products per group and last group index of each multiply state
  always_comb begin
    is_prod = 1'b1;
    kmax    = 3'd0;
    gmax    = 2'd0;
    case (state)
      S_CROSS_N: begin kmax = 3'd2; gmax = 2'd2; end
      S_SQ:      begin kmax = 3'd3; gmax = 2'd0; end
      S_DOT:     begin kmax = 3'd3; gmax = 2'd1; end
      S_PT:      begin kmax = 3'd1; gmax = 2'd2; end
      S_CROSS_E: begin kmax = 3'd2; gmax = 2'd2; end
      S_EDOT:    begin kmax = 3'd6; gmax = 2'd0; end
      default:   is_prod = 1'b0;
    endcase
    grp_last = is_prod && (stp == kmax) && (grp == gmax);
  end

  // Next state
  always_comb begin
    state_next = state;
    sts_val    = ST_HIT;
    case (state)
      S_IDLE: begin
        if (item_accept && (mode == MODE_CHECK) && (cnt_in != 7'd0)) state_next = S_READ;
      end
      S_READ:    if (stp == 3'd3) state_next = S_PREP;
      S_PREP:    state_next = S_CROSS_N;
      S_CROSS_N: if (grp_last) state_next = S_SHIFT;
      S_SHIFT:   if (all_in) state_next = S_SQ;
      S_SQ:      if (grp_last) state_next = S_SQRT;
      S_SQRT:    if (itr == 5'd31) state_next = S_UDIV_INIT;
      S_UDIV_INIT: begin
        if (len == 32'd0) begin
          state_next = S_EMIT;
          sts_val    = ST_PARALLEL;
        end else begin
          state_next = S_UDIV;
        end
      end
      S_UDIV: begin
        if (itr == 5'd30) state_next = (ug == 2'd2) ? S_DOT : S_UDIV_INIT;
      end
      S_DOT: if (grp_last) state_next = S_CHECK;
      S_CHECK: begin
        if (dn == 0 || dn < thr_ext) begin
          state_next = S_EMIT;
          sts_val    = ST_PARALLEL;
        end else if (num < 0 || num > dn) begin
          state_next = S_EMIT;
          sts_val    = ST_OUTSIDE_SEG;
        end else if (num == dn) begin
          state_next = S_PT;
        end else begin
          state_next = S_TDIV;
        end
      end
      S_TDIV:    if (itr == 5'd29) state_next = S_PT;
      S_PT:      if (grp_last) state_next = S_EPREP;
      S_EPREP:   state_next = S_CROSS_E;
      S_CROSS_E: if (grp_last) state_next = S_EDOT;
      S_EDOT: begin
        if (grp_last) begin
          if (acc_sum > 0) begin
            state_next = S_EMIT;
            sts_val    = ST_OUTSIDE_TRI;
          end else if (eidx == 2'd2) begin
            state_next = S_EMIT;
            sts_val    = ST_HIT;
          end else begin
            state_next = S_EPREP;
          end
        end
      end
      S_EMIT:  if (out_free) state_next = last_now ? S_IDLE : S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: stall, store read address, multiplier operands, edge vertices
  always_comb begin
    item_stall = (state != S_IDLE);
    rd_addr    = AW'(8'(tri_cnt) * 8'(NUM_CORNERS) + 8'(stp));
    mul_a      = '0;
    mul_b      = '0;
    mul_en     = is_prod && (stp != kmax);
    mul_neg    = 1'b0;
    mul_shl    = 1'b0;
    for (int k = 0; k < 3; k++) begin
      psrc[k] = (state == S_CROSS_N) ? e2[k] : ee[k];
      qsrc[k] = (state == S_CROSS_N) ? e1[k] : ew[k];
    end
    case (grp)
      2'd0:    begin xa0 = psrc[1]; xb0 = qsrc[2]; xa1 = psrc[2]; xb1 = qsrc[1]; end
      2'd1:    begin xa0 = psrc[2]; xb0 = qsrc[0]; xa1 = psrc[0]; xb1 = qsrc[2]; end
      default: begin xa0 = psrc[0]; xb0 = qsrc[1]; xa1 = psrc[1]; xb1 = qsrc[0]; end
    endcase
    case (state)
      S_CROSS_N, S_CROSS_E: begin
        mul_a   = (stp == 3'd0) ? MUL_W'(xa0) : MUL_W'(xa1);
        mul_b   = (stp == 3'd0) ? MUL_W'(xb0) : MUL_W'(xb1);
        mul_neg = (stp == 3'd1);
      end
      S_SQ: begin
        case (stp)
          3'd0:    begin mul_a = MUL_W'(mv[0]); mul_b = MUL_W'(mv[0]); end
          3'd1:    begin mul_a = MUL_W'(mv[1]); mul_b = MUL_W'(mv[1]); end
          default: begin mul_a = MUL_W'(mv[2]); mul_b = MUL_W'(mv[2]); end
        endcase
      end
      S_DOT: begin
        case (stp)
          3'd0: begin
            mul_a = MUL_W'(u[0]);
            mul_b = grp[0] ? MUL_W'(w0[0]) : MUL_W'(cd[0]);
          end
          3'd1: begin
            mul_a = MUL_W'(u[1]);
            mul_b = grp[0] ? MUL_W'(w0[1]) : MUL_W'(cd[1]);
          end
          default: begin
            mul_a = MUL_W'(u[2]);
            mul_b = grp[0] ? MUL_W'(w0[2]) : MUL_W'(cd[2]);
          end
        endcase
      end
      S_PT: begin
        mul_b = MUL_W'(tq);
        case (grp)
          2'd0:    mul_a = MUL_W'(cd[0]);
          2'd1:    mul_a = MUL_W'(cd[1]);
          default: mul_a = MUL_W'(cd[2]);
        endcase
      end
      S_EDOT: begin
        mul_shl = !stp[0];
        case (stp)
          3'd0:    begin mul_a = MUL_W'(chi[0]); mul_b = MUL_W'(u[0]); end
          3'd1:    begin mul_a = MUL_W'(clo[0]); mul_b = MUL_W'(u[0]); end
          3'd2:    begin mul_a = MUL_W'(chi[1]); mul_b = MUL_W'(u[1]); end
          3'd3:    begin mul_a = MUL_W'(clo[1]); mul_b = MUL_W'(u[1]); end
          3'd4:    begin mul_a = MUL_W'(chi[2]); mul_b = MUL_W'(u[2]); end
          default: begin mul_a = MUL_W'(clo[2]); mul_b = MUL_W'(u[2]); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    case (eidx)
      2'd0:    begin va = v[0]; vb = v[1]; end
      2'd1:    begin va = v[1]; vb = v[2]; end
      default: begin va = v[2]; vb = v[0]; end
    endcase
  end

  assign term    = p_shl ? (ACW'(prod) <<< LOW) : ACW'(prod);
  assign acc_sum = acc + (p_en ? (p_neg ? -term : term) : ACW'(0));

  // Vertex store: one corner per word
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {cin_a[2], cin_a[1], cin_a[0]};
    rd_data <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      result_valid       <= 1'b0;
      p_en               <= 1'b0;
      triangle_count     <= 7'd0;
      parallel_threshold <= 16'(THRESH_RESET);
      stp                <= '0;
      grp                <= '0;
      itr                <= '0;
    end else begin
      state <= state_next;
      p_en  <= mul_en;
      if (cfg_write) begin
        if (paddr[2] == REG_COUNT) triangle_count <= pwdata[6:0];
        else parallel_threshold <= pwdata[15:0];
      end
      if (state == S_EMIT && out_free) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
      if (state_next != state) begin
        stp <= '0;
        grp <= '0;
        itr <= '0;
      end else if (is_prod) begin
        if (stp == kmax) begin
          stp <= '0;
          grp <= grp + 2'd1;
        end else begin
          stp <= stp + 3'd1;
        end
      end else begin
        stp <= stp + 3'd1;
        itr <= itr + 5'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod  <= mul_a * mul_b;
    p_neg <= mul_neg;
    p_shl <= mul_shl;
    if ((is_prod && stp == kmax) || state == S_IDLE) acc <= '0;
    else acc <= acc_sum;
    if (state_next == S_EMIT && state != S_EMIT) sts <= sts_val;

    case (state)
      S_IDLE: begin
        if (item_accept && mode == MODE_CHECK) begin
          for (int k = 0; k < 3; k++) begin
            ca[k] <= cin_a[k];
            cd[k] <= EW'(cin_b[k]) - EW'(cin_a[k]);
          end
          cnt     <= cnt_in;
          tri_cnt <= '0;
        end
      end
      S_READ: begin
        for (int k = 0; k < 3; k++) begin
          case (stp)
            3'd1:    v[0][k] <= rd_data[k*CW +: CW];
            3'd2:    v[1][k] <= rd_data[k*CW +: CW];
            3'd3:    v[2][k] <= rd_data[k*CW +: CW];
            default: ;
          endcase
        end
      end
      S_PREP: begin
        for (int k = 0; k < 3; k++) begin
          e1[k] <= EW'(v[1][k]) - EW'(v[0][k]);
          e2[k] <= EW'(v[2][k]) - EW'(v[0][k]);
          w0[k] <= EW'(v[0][k]) - EW'(ca[k]);
        end
      end
      S_CROSS_N: begin
        if (stp == kmax) begin
          case (grp)
            2'd0:    nv[0] <= NW'(acc_sum);
            2'd1:    nv[1] <= NW'(acc_sum);
            default: nv[2] <= NW'(acc_sum);
          endcase
        end
      end
      S_SHIFT: begin
        if (!all_in) begin
          for (int k = 0; k < 3; k++) nv[k] <= nv[k] >>> 1;
        end
      end
      S_SQ: begin
        if (stp == kmax) begin
          sq_x   <= 64'(acc_sum);
          sq_res <= 64'd0;
          sq_one <= 64'd1 << 62;
          ug     <= 2'd0;
        end
      end
      S_SQRT: begin
        if (sq_x >= sq_t) begin
          sq_x   <= sq_x - sq_t;
          sq_res <= (sq_res >> 1) + sq_one;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_one <= sq_one >> 2;
      end
      S_UDIV_INIT: begin
        drem  <= 32'(dnum[61:31]);
        dlow  <= dnum[30:0];
        dq    <= '0;
      end
      S_UDIV: begin
        if (dtt >= 33'(len)) drem <= 32'(dtt - 33'(len));
        else drem <= 32'(dtt);
        dlow <= {dlow[29:0], 1'b0};
        dq   <= dq_nx;
        if (itr == 5'd30) begin
          case (ug)
            2'd0:    u[0] <= usign ? -$signed(32'(dq_nx)) : $signed(32'(dq_nx));
            2'd1:    u[1] <= usign ? -$signed(32'(dq_nx)) : $signed(32'(dq_nx));
            default: u[2] <= usign ? -$signed(32'(dq_nx)) : $signed(32'(dq_nx));
          endcase
          ug <= ug + 2'd1;
        end
      end
      S_DOT: begin
        if (stp == kmax) begin
          if (grp[0]) num <= DNW'(acc_sum);
          else dn <= DNW'(acc_sum);
        end
      end
      S_CHECK: begin
        rem  <= DNW'($unsigned(num));
        tq   <= (num == dn) ? (31'd1 << 30) : 31'd0;
        eidx <= 2'd0;
      end
      S_TDIV: begin
        if (rem2 >= dn_u) begin
          rem <= DNW'(rem2 - dn_u);
          tq  <= {tq[29:0], 1'b1};
        end else begin
          rem <= DNW'(rem2);
          tq  <= {tq[29:0], 1'b0};
        end
      end
      S_PT: begin
        if (stp == kmax) begin
          case (grp)
            2'd0:    pp[0] <= CW'(ca[0] + ((acc_sum + (ACW'(1) <<< 29)) >>> 30));
            2'd1:    pp[1] <= CW'(ca[1] + ((acc_sum + (ACW'(1) <<< 29)) >>> 30));
            default: pp[2] <= CW'(ca[2] + ((acc_sum + (ACW'(1) <<< 29)) >>> 30));
          endcase
        end
      end
      S_EPREP: begin
        for (int k = 0; k < 3; k++) begin
          ee[k] <= EW'(vb[k]) - EW'(va[k]);
          ew[k] <= EW'(pp[k]) - EW'(va[k]);
        end
      end
      S_CROSS_E: begin
        if (stp == kmax) begin
          case (grp)
            2'd0:    cc[0] <= NW'(acc_sum);
            2'd1:    cc[1] <= NW'(acc_sum);
            default: cc[2] <= NW'(acc_sum);
          endcase
        end
      end
      S_EDOT: begin
        if (stp == kmax) eidx <= eidx + 2'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          hit_index <= 6'(tri_cnt);
          status    <= sts;
          last      <= last_now;
          if (sts == ST_OUTSIDE_TRI || sts == ST_HIT) begin
            px <= FIELD_W'(pp[0]);
            py <= FIELD_W'(pp[1]);
            pz <= FIELD_W'(pp[2]);
          end else begin
            px <= '0;
            py <= '0;
            pz <= '0;
          end
          tri_cnt <= tri_cnt + TIW'(1);
        end
      end
      default: ;
    endcase
  end

  // Rounded divide setup for u = m * 2^30 / len
  always_comb begin
    case (ug)
      2'd0:    begin usign = mv[0] < 0; mabs = mv[0] < 0 ? 31'(-mv[0]) : 31'(mv[0]); end
      2'd1:    begin usign = mv[1] < 0; mabs = mv[1] < 0 ? 31'(-mv[1]) : 31'(mv[1]); end
      default: begin usign = mv[2] < 0; mabs = mv[2] < 0 ? 31'(-mv[2]) : 31'(mv[2]); end
    endcase
    dnum = 62'({mabs, 30'd0}) + 62'(len >> 1);
  end

  `STC_ASSERT_IMP(a_index_below_count, clk, rst, result_valid, (7'(hit_index) < cnt))
  `STC_ASSERT_IMP(a_point_zero_on_miss, clk, rst, result_valid && (status == ST_PARALLEL || status == ST_OUTSIDE_SEG), (px == 0 && py == 0 && pz == 0))
  `STC_ASSERT_IMP(a_rem_below_dn, clk, rst, state == S_TDIV, ({1'b0, rem} < dn_u))
  `STC_ASSERT_NEXT(a_load_stays_idle, clk, rst, item_accept && mode == MODE_LOAD, state == S_IDLE)

endmodule
